@@ rtl/core/swrc_pkg.sv @@
// Package for the sliding window range convergence detector.
// Holds field widths, register reset values, config indexes and the sequencer state type.
// No dependencies.
package swrc_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int LEN_W           = 11;
    localparam int THR_W           = 32;
    localparam int CFG_IDX_W       = 1;
    localparam int WINDOW_MAX_DEF  = 1024;

    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(66);
    localparam logic [LEN_W-1:0] LEN_RESET    = LEN_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

@@ rtl/core/sliding_window_range_convergence.sv @@
// Sliding window range detector: ring store of samples, rescanned per beat.
// Depends on swrc_pkg.
// Sequence per beat: SETUP loads the oldest slot and n = min(samples seen, window length),
//   SCAN walks the window one entry a cycle on the single read port of the sample store through one max/min
//   compare unit, DONE waits for a free result register; o_stall holds new beats off until IDLE.
// Reset: synchronous active low; clears the write pointer, counts and handshakes; the store is not cleared.
module sliding_window_range_convergence #(
    parameter int P_WINDOW_MAX = swrc_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beat
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [swrc_pkg::SAMPLE_W-1:0]    i_sample,
    // result beat
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_converged,
    output logic [swrc_pkg::SAMPLE_W-1:0]    o_window_max,
    output logic [swrc_pkg::SAMPLE_W-1:0]    o_window_min,
    output logic                             o_window_full,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swrc_pkg::THR_W-1:0]       i_cfg_data
);

    localparam int AW = (P_WINDOW_MAX > 1) ? $clog2(P_WINDOW_MAX) : 1;
    localparam int CW = AW + 1;                  // holds counts up to P_WINDOW_MAX
    localparam int EW = (CW > swrc_pkg::LEN_W) ? CW : swrc_pkg::LEN_W;
    localparam logic [CW-1:0] WMAX     = CW'(P_WINDOW_MAX);
    localparam logic [AW-1:0] LAST_IDX = AW'(P_WINDOW_MAX - 1);

    // Sample ring store, one write and one registered read per cycle.
    logic [swrc_pkg::SAMPLE_W-1:0] r_mem [P_WINDOW_MAX];

    swrc_pkg::t_state r_state, n_state;

    logic [swrc_pkg::THR_W-1:0]    r_thresh;
    logic [swrc_pkg::LEN_W-1:0]    r_wlen;

    logic [AW-1:0]                 r_wp;       // next ring slot to write
    logic [CW-1:0]                 r_seen;     // saturates at P_WINDOW_MAX
    logic [CW-1:0]                 r_len;      // effective window length for this beat
    logic [AW-1:0]                 r_addr;     // scan read address
    logic [CW-1:0]                 r_left;     // reads still to issue
    logic                          r_rd_vld;
    logic [swrc_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                          r_first;
    logic [swrc_pkg::SAMPLE_W-1:0] r_max;
    logic [swrc_pkg::SAMPLE_W-1:0] r_min;

    logic                          r_out_vld;
    logic                          r_out_conv;
    logic                          r_out_full;
    logic [swrc_pkg::SAMPLE_W-1:0] r_out_max;
    logic [swrc_pkg::SAMPLE_W-1:0] r_out_min;

    logic                          in_acc;
    logic                          out_free;
    logic [EW-1:0]                 wlen_ext;
    logic [CW-1:0]                 eff_len;
    logic [CW-1:0]                 scan_n;
    logic [CW-1:0]                 wp_ext;
    logic [CW-1:0]                 start_ext;
    logic [AW-1:0]                 wp_inc;
    logic [AW-1:0]                 addr_inc;
    logic                          full;
    logic [swrc_pkg::SAMPLE_W-1:0] range;

    assign o_stall     = (r_state != swrc_pkg::S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_vld || !i_stall;
    assign o_cfg_ready = 1'b1;

    // Clamp the window length register to 1 .. P_WINDOW_MAX.
    always_comb begin
        wlen_ext = EW'(r_wlen);
        if (wlen_ext == '0) begin
            eff_len = CW'(1);
        end else if (wlen_ext > EW'(P_WINDOW_MAX)) begin
            eff_len = WMAX;
        end else begin
            eff_len = CW'(wlen_ext);
        end
    end

    // Oldest slot of the window: write pointer minus n, modulo the ring size.
    always_comb begin
        scan_n = (r_seen < r_len) ? r_seen : r_len;
        wp_ext = CW'(r_wp);
        if (wp_ext >= scan_n) begin
            start_ext = wp_ext - scan_n;
        end else begin
            start_ext = wp_ext + WMAX - scan_n;
        end
    end

    assign wp_inc   = (r_wp == LAST_IDX) ? '0 : r_wp + AW'(1);
    assign addr_inc = (r_addr == LAST_IDX) ? '0 : r_addr + AW'(1);
    assign full     = (r_seen >= r_len);
    assign range    = r_max - r_min;

    always_comb begin
        n_state = r_state;
        case (r_state)
            swrc_pkg::S_IDLE:  if (in_acc) n_state = swrc_pkg::S_SETUP;
            swrc_pkg::S_SETUP: n_state = swrc_pkg::S_SCAN;
            swrc_pkg::S_SCAN:  if (r_left == '0 && !r_rd_vld) n_state = swrc_pkg::S_DONE;
            swrc_pkg::S_DONE:  if (out_free) n_state = swrc_pkg::S_IDLE;
            default:           n_state = swrc_pkg::S_IDLE;
        endcase
    end

    // Store write on accept, scan read while walking the window.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_wp] <= i_sample;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swrc_pkg::S_IDLE;
            r_thresh  <= swrc_pkg::THRESH_RESET;
            r_wlen    <= swrc_pkg::LEN_RESET;
            r_wp      <= '0;
            r_seen    <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_first   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    swrc_pkg::CFG_THRESHOLD:  r_thresh <= i_cfg_data;
                    swrc_pkg::CFG_WINDOW_LEN: r_wlen   <= i_cfg_data[swrc_pkg::LEN_W-1:0];
                    default:                  r_thresh <= r_thresh;
                endcase
            end

            // Advance the ring and count the beat.
            if (in_acc) begin
                r_wp <= wp_inc;
                if (r_seen < WMAX) begin
                    r_seen <= r_seen + CW'(1);
                end
            end

            if (r_state == swrc_pkg::S_SETUP) begin
                r_left  <= scan_n;
                r_first <= 1'b1;
            end else if (r_state == swrc_pkg::S_SCAN) begin
                if (r_left != '0) begin
                    r_left <= r_left - CW'(1);
                end
                if (r_rd_vld) begin
                    r_first <= 1'b0;
                end
            end

            r_rd_vld <= (r_state == swrc_pkg::S_SCAN) && (r_left != '0);

            // Hold the result until the downstream side takes it.
            if (r_state == swrc_pkg::S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_len <= eff_len;
        end
        if (r_state == swrc_pkg::S_SETUP) begin
            r_addr <= start_ext[AW-1:0];
        end else if (r_state == swrc_pkg::S_SCAN && r_left != '0) begin
            r_addr <= addr_inc;
        end
        // Shared max/min compare unit, one stored sample per cycle.
        if (r_state == swrc_pkg::S_SCAN && r_rd_vld) begin
            if (r_first || r_rd_data >= r_max) r_max <= r_rd_data;
            if (r_first || r_rd_data <= r_min) r_min <= r_rd_data;
        end
        if (r_state == swrc_pkg::S_DONE && out_free) begin
            r_out_full <= full;
            r_out_conv <= full && (range < r_thresh);
            r_out_max  <= r_max;
            r_out_min  <= r_min;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_converged   = r_out_conv;
    assign o_window_max  = r_out_max;
    assign o_window_min  = r_out_min;
    assign o_window_full = r_out_full;

    // Checks on the sequencer and the result datapath.
    a_conv_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_converged || o_window_full))
        else $error("converged set on a window that is not full");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_max >= o_window_min))
        else $error("window max below window min");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == swrc_pkg::S_SETUP))
        else $error("accepted beat did not start a scan");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen <= WMAX) && (r_left <= WMAX))
        else $error("sample count or scan count beyond ring size");

endmodule
